// ===== hw/rtl/gbns_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the go-back-N sender window unit.
// No dependencies; the RTL files that use it refer to it by scoped names, the bench imports it.
package gbns_pkg;

  // Default sizing
  localparam int RING_DEPTH_DEF   = 32;
  localparam int PACKET_BYTES_DEF = 52;

  // Divide by ten through a reciprocal: x/10 == (x*52429) >> 19 for 16-bit x
  localparam logic [15:0] RECIP_TENTH = 16'd52429;
  localparam int          TENTH_SHIFT = 19;

  // Command codes of an input item
  localparam logic [2:0] CMD_DATA    = 3'd0;
  localparam logic [2:0] CMD_ACK     = 3'd1;
  localparam logic [2:0] CMD_TIMEOUT = 3'd2;
  localparam logic [2:0] CMD_SYNACK  = 3'd3;

  // Result kinds
  localparam logic [2:0] KIND_NEW     = 3'd0;
  localparam logic [2:0] KIND_RETX    = 3'd1;
  localparam logic [2:0] KIND_HSK     = 3'd2;
  localparam logic [2:0] KIND_REFUSED = 3'd3;
  localparam logic [2:0] KIND_NONE    = 3'd4;

  // Configuration register indexes
  localparam int          CFG_IDX_W    = 1;
  localparam logic [0:0]  CFG_ADV_WIN  = 1'd0;
  localparam logic [0:0]  CFG_FIRST_SQ = 1'd1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] payload_handle;
    logic [15:0] ack_number;
    logic [15:0] peer_sequence;
    logic        ecn_mark;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_sequence;
    logic [15:0] out_ack_number;
    logic [15:0] out_payload;
    logic [15:0] congestion_bytes;
    logic        last;
  } out_item_t;

  // Window update request from the sequencer to the window unit
  typedef struct packed {
    logic commit;
    logic ecn;
    logic grow;
    logic reset_one;
    logic halve;
  } cwnd_ctl_t;

endpackage

// ===== hw/rtl/gbns_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gbns_cwnd.sv =====
`timescale 1ns / 1ps
// Congestion window register and its update arithmetic.
// Depends on gbns_pkg for the control struct and the tenth reciprocal.
module gbns_cwnd #(
  parameter int PACKET_BYTES = gbns_pkg::PACKET_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gbns_pkg::cwnd_ctl_t ctl,
  output logic [15:0]         cw
);

  localparam logic [16:0] PB17  = 17'(PACKET_BYTES);
  localparam logic [16:0] WMAX  = 17'(65535);

  logic [15:0] cw_r, cw_nxt;
  logic [31:0] prod_r;
  logic [15:0] tenth;
  logic [16:0] w_ecn, w_add, w_upd, w_fin;

  // Window times reciprocal of ten, registered ahead of the commit cycle
  always_ff @(posedge clk) begin
    prod_r <= 32'(cw_r) * 32'(gbns_pkg::RECIP_TENTH);
  end

  // Cut, grow, reset or halve, then floor at one packet
  always_comb begin
    tenth = 16'(prod_r[31:gbns_pkg::TENTH_SHIFT]);
    w_ecn = ctl.ecn ? 17'(cw_r - tenth) : 17'(cw_r);
    w_add = w_ecn + PB17;
    w_upd = w_ecn;
    if (ctl.grow) begin
      w_upd = (w_add > WMAX) ? WMAX : w_add;
    end
    if (ctl.reset_one) begin
      w_upd = PB17;
    end
    if (ctl.halve) begin
      w_upd = 17'(cw_r >> 1);
    end
    w_fin  = (w_upd < PB17) ? PB17 : w_upd;
    cw_nxt = ctl.commit ? w_fin[15:0] : cw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= PB17[15:0];
    end else begin
      cw_r <= cw_nxt;
    end
  end

  assign cw = cw_r;

endmodule

// ===== hw/rtl/go_back_n_sender_window_unit.sv =====
`timescale 1ns / 1ps
// Go-back-N sender: new data and unknown commands are decoded in the evaluate state and
// give a single registered result. Acks, timeouts and syn-acks pass through decode, window
// update and post states, then stream any retransmits from the ring RAM at one per cycle
// after a registered read; with nothing to resend they give a single result instead.
// Synchronous active-low reset: window one packet, sequences zero, ring empty.
// Results cannot be stalled; each result shows for one cycle on out_valid.
module go_back_n_sender_window_unit #(
  parameter int RING_DEPTH   = gbns_pkg::RING_DEPTH_DEF,
  parameter int PACKET_BYTES = gbns_pkg::PACKET_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  gbns_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output gbns_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gbns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);

  localparam int HW   = $clog2(RING_DEPTH);
  localparam int CNTW = $clog2(RING_DEPTH + 1);
  localparam int PBW  = $clog2(PACKET_BYTES + 1);
  localparam int MW   = 17 + PBW;
  localparam logic [CNTW:0] DEPTH_W = (CNTW + 1)'(RING_DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_WIN    = 3'd2;
  localparam logic [2:0] ST_POST   = 3'd3;
  localparam logic [2:0] ST_RESEND = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       adv_r, adv_nxt;
  logic [15:0]      base_r, base_nxt;
  logic [15:0]      next_r, next_nxt;
  logic [15:0]      lack_r, lack_nxt;
  logic [1:0]       dc_r, dc_nxt;
  logic [HW-1:0]    head_r, head_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  // Latched input item
  gbns_pkg::in_item_t item_r, item_nxt;

  // Decisions carried from decode to the window commit
  logic ecn_f_r, ecn_f_nxt;
  logic grow_r, grow_nxt;
  logic one_r, one_nxt;
  logic halve_r, halve_nxt;
  logic resend_r, resend_nxt;

  // Retransmit walk and read pipeline
  logic [CNTW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [HW-1:0]    rd_slot_r, rd_slot_nxt;
  logic [15:0]      rd_seq_r, rd_seq_nxt;
  logic             pv_r, pv_nxt;
  logic             plast_r, plast_nxt;
  logic [15:0]      pseq_r, pseq_nxt;

  logic                out_valid_r, out_valid_nxt;
  gbns_pkg::out_item_t out_r, out_nxt;

  // RAM and window unit hookups
  logic                ram_we, ram_re;
  logic [HW-1:0]       ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;
  gbns_pkg::cwnd_ctl_t cw_ctl;
  logic [15:0]         cw;

  // Decode helpers
  logic [15:0]   outst, ack_gap;
  logic [16:0]   outst1;
  logic [MW-1:0] need_bytes;
  logic          admit, inorder, pop_ok, dup3;
  logic [CNTW-1:0] pop_n;
  logic [CNTW:0] wsum, psum;
  logic [HW-1:0] wslot, pslot;
  logic [1:0]    dc_inc;
  logic          issue;

  gbns_ram #(
    .WIDTH (16),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbns_cwnd #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_cwnd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cw_ctl),
    .cw    (cw)
  );

  // Window admission and ack distance
  always_comb begin
    outst      = next_r - base_r;
    outst1     = 17'(outst) + 17'd1;
    need_bytes = MW'(outst1) * MW'(PACKET_BYTES);
    admit      = (outst1 <= 17'(adv_r)) && (need_bytes <= MW'(cw)) &&
                 ((CNTW + 1)'(count_r) < DEPTH_W);
    ack_gap    = item_r.ack_number - base_r;
    inorder    = (ack_gap == 16'd1) && (outst != 16'd0) && (count_r != '0);
    pop_ok     = (ack_gap != 16'd0) && !ack_gap[15] && (ack_gap <= outst) &&
                 (ack_gap <= 16'(count_r));
    pop_n      = inorder ? CNTW'(1) : (pop_ok ? ack_gap[CNTW-1:0] : '0);
    wsum       = (CNTW + 1)'(head_r) + (CNTW + 1)'(count_r);
    wslot      = (wsum >= DEPTH_W) ? HW'(wsum - DEPTH_W) : HW'(wsum);
    psum       = (CNTW + 1)'(head_r) + (CNTW + 1)'(pop_n);
    pslot      = (psum >= DEPTH_W) ? HW'(psum - DEPTH_W) : HW'(psum);
    dc_inc     = (item_r.ack_number == lack_r) ? dc_r + 2'd1 : 2'd0;
    dup3       = !inorder && (dc_inc == 2'd3);
    issue      = (state_r == ST_RESEND) && (rd_idx_r < count_r);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    adv_nxt       = adv_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    lack_nxt      = lack_r;
    dc_nxt        = dc_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    item_nxt      = item_r;
    ecn_f_nxt     = ecn_f_r;
    grow_nxt      = grow_r;
    one_nxt       = one_r;
    halve_nxt     = halve_r;
    resend_nxt    = resend_r;
    rd_idx_nxt    = rd_idx_r;
    rd_slot_nxt   = rd_slot_r;
    rd_seq_nxt    = rd_seq_r;
    pv_nxt        = 1'b0;
    plast_nxt     = plast_r;
    pseq_nxt      = pseq_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = wslot;
    ram_wdata     = item_r.payload_handle;
    ram_re        = issue;
    ram_raddr     = rd_slot_r;
    cw_ctl        = '0;

    // Apply configuration writes while idle
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbns_pkg::CFG_ADV_WIN: begin
          adv_nxt = cfg_data[7:0];
        end
        gbns_pkg::CFG_FIRST_SQ: begin
          base_nxt  = cfg_data;
          next_nxt  = cfg_data;
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        ecn_f_nxt  = 1'b0;
        grow_nxt   = 1'b0;
        one_nxt    = 1'b0;
        halve_nxt  = 1'b0;
        resend_nxt = 1'b0;
        state_nxt  = ST_WIN;
        case (item_r.command)
          gbns_pkg::CMD_DATA: begin
            // Send into the ring or refuse
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.congestion_bytes = cw;
            out_nxt.last  = 1'b1;
            if (admit) begin
              ram_we               = 1'b1;
              count_nxt            = count_r + CNTW'(1);
              next_nxt             = next_r + 16'd1;
              out_nxt.kind         = gbns_pkg::KIND_NEW;
              out_nxt.out_sequence = next_r;
              out_nxt.out_payload  = item_r.payload_handle;
            end else begin
              out_nxt.kind = gbns_pkg::KIND_REFUSED;
            end
            state_nxt = ST_IDLE;
          end
          gbns_pkg::CMD_ACK: begin
            // Pop acked entries, count duplicates
            ecn_f_nxt = item_r.ecn_mark;
            grow_nxt  = inorder;
            head_nxt  = pslot;
            count_nxt = count_r - pop_n;
            base_nxt  = base_r + 16'(pop_n);
            if (!inorder) begin
              lack_nxt   = item_r.ack_number;
              dc_nxt     = dup3 ? 2'd0 : dc_inc;
              one_nxt    = dup3;
              resend_nxt = dup3;
            end
          end
          gbns_pkg::CMD_TIMEOUT: begin
            halve_nxt  = 1'b1;
            resend_nxt = 1'b1;
          end
          gbns_pkg::CMD_SYNACK: begin
            resend_nxt = 1'b1;
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.kind  = gbns_pkg::KIND_NONE;
            out_nxt.congestion_bytes = cw;
            out_nxt.last  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end

      ST_WIN: begin
        // Commit the window update
        cw_ctl.commit    = 1'b1;
        cw_ctl.ecn       = ecn_f_r;
        cw_ctl.grow      = grow_r;
        cw_ctl.reset_one = one_r;
        cw_ctl.halve     = halve_r;
        state_nxt        = ST_POST;
      end

      ST_POST: begin
        rd_idx_nxt  = '0;
        rd_slot_nxt = head_r;
        rd_seq_nxt  = base_r;
        out_nxt     = '0;
        out_nxt.congestion_bytes = cw;
        if (item_r.command == gbns_pkg::CMD_SYNACK) begin
          // Handshake ack ahead of the retransmits
          out_valid_nxt          = 1'b1;
          out_nxt.kind           = gbns_pkg::KIND_HSK;
          out_nxt.out_sequence   = item_r.ack_number + 16'd1;
          out_nxt.out_ack_number = item_r.peer_sequence + 16'd1;
          out_nxt.last           = (count_r == '0);
          state_nxt = (count_r == '0) ? ST_IDLE : ST_RESEND;
        end else if (resend_r && (count_r != '0)) begin
          state_nxt = ST_RESEND;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = gbns_pkg::KIND_NONE;
          out_nxt.last  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_RESEND: begin
        // Walk the ring, one read a cycle
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + CNTW'(1);
          rd_slot_nxt = ((CNTW + 1)'(rd_slot_r) == DEPTH_W - (CNTW + 1)'(1)) ?
                        '0 : rd_slot_r + HW'(1);
          rd_seq_nxt  = rd_seq_r + 16'd1;
          pv_nxt      = 1'b1;
          pseq_nxt    = rd_seq_r;
          plast_nxt   = (rd_idx_r == count_r - CNTW'(1));
        end
        if (pv_r) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.kind         = gbns_pkg::KIND_RETX;
          out_nxt.out_sequence = pseq_r;
          out_nxt.out_payload  = ram_rdata;
          out_nxt.congestion_bytes = cw;
          out_nxt.last         = plast_r;
          if (plast_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      adv_r       <= 8'd1;
      base_r      <= 16'd0;
      next_r      <= 16'd0;
      lack_r      <= 16'd0;
      dc_r        <= 2'd0;
      head_r      <= '0;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      adv_r       <= adv_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      lack_r      <= lack_nxt;
      dc_r        <= dc_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    ecn_f_r   <= ecn_f_nxt;
    grow_r    <= grow_nxt;
    one_r     <= one_nxt;
    halve_r   <= halve_nxt;
    resend_r  <= resend_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_slot_r <= rd_slot_nxt;
    rd_seq_r  <= rd_seq_nxt;
    plast_r   <= plast_nxt;
    pseq_r    <= pseq_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/gbns_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the go-back-N sender window unit, bound to the top.
// Depends on gbns_pkg for result kinds and the item struct.
module gbns_chk #(
  parameter int PACKET_BYTES = gbns_pkg::PACKET_BYTES_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input gbns_pkg::out_item_t out_data
);

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // No result shows in the first busy cycle
  a_rise_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result shown as busy rose");

  // The last result of an item is never followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result right after last");

  // Single-result kinds always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == gbns_pkg::KIND_NEW ||
                  out_data.kind == gbns_pkg::KIND_REFUSED ||
                  out_data.kind == gbns_pkg::KIND_NONE) |-> out_data.last)
    else $error("single-result kind without last");

  // Window never drops under one packet
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.congestion_bytes >= 16'(PACKET_BYTES)))
    else $error("window below one packet");

endmodule

bind go_back_n_sender_window_unit gbns_chk #(
  .PACKET_BYTES (PACKET_BYTES)
) u_gbns_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== verif/go_back_n_sender_window_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for go_back_n_sender_window_unit: drives packet events and
// register writes, predicts every emitted packet, and checks each one in order.
// Depends on gbns_pkg and the go_back_n_sender_window_unit RTL only.
module go_back_n_sender_window_unit_tb;
  import gbns_pkg::*;

  localparam int          PKT_BYTES     = PACKET_BYTES_DEF;
  localparam int          RING_SLOTS    = RING_DEPTH_DEF;
  localparam int unsigned WIN_CAP       = 65535;
  localparam int unsigned ECN_DIVISOR   = 10;
  localparam int          DUP_TRIGGER   = 3;
  localparam logic [2:0]  CMD_OTHER     = 3'd4;
  localparam logic [2:0]  CMD_LAST_CODE = 3'd7;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          reg_val;
    in_item_t             item;
  } backlog_entry_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_data = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // Pending stimulus and packets still owed by the block
  backlog_entry_t event_backlog[$];
  out_item_t      due_results[$];
  out_item_t      step_pkts[$];

  // Sender state as the bench tracks it (power-up equals reset state)
  logic [7:0]  win_adv = 8'd1;
  logic [15:0] base_sq = '0;
  logic [15:0] next_sq = '0;
  logic [15:0] last_ack = '0;
  logic [1:0]  dup_cnt = '0;
  logic [15:0] ring_mem [RING_SLOTS];
  int unsigned cwnd = PKT_BYTES;
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;
  int unsigned peak_fill = 0;

  bit item_acc = 1'b0;
  bit cfg_acc = 1'b0;
  int gap_left = 0;
  int calm_left = 0;

  int mismatch_cnt = 0;
  int checked_cnt = 0;
  int events_cnt = 0;
  int writes_cnt = 0;
  int kind_cnt [5] = '{default: 0};

  go_back_n_sender_window_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic out_item_t mk_result(input logic [2:0] kind, input logic [15:0] sq,
                                          input logic [15:0] ackn, input logic [15:0] pay);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.out_sequence = sq;
    r.out_ack_number = ackn;
    r.out_payload = pay;
    return r;
  endfunction

  // Queue a retransmit of every packet still in the ring, oldest first
  task automatic queue_resends();
    for (int i = 0; i < ring_fill; i++)
      step_pkts.push_back(mk_result(KIND_RETX, base_sq + 16'(i), 16'h0,
                                    ring_mem[(ring_head + i) % RING_SLOTS]));
  endtask

  task automatic drop_acked(input int unsigned n);
    ring_head = (ring_head + n) % RING_SLOTS;
    ring_fill -= n;
    base_sq = base_sq + 16'(n);
  endtask

  // Work out the packets one accepted event causes and advance the state
  task automatic predict_sender(input in_item_t ev);
    logic [15:0] gap_out;
    logic [15:0] ack_gap;
    int unsigned eff;
    gap_out = next_sq - base_sq;
    step_pkts.delete();
    case (ev.command)
      CMD_DATA: begin
        eff = win_adv * PKT_BYTES;
        if (cwnd < eff) eff = cwnd;
        if (gap_out < eff / PKT_BYTES && ring_fill < RING_SLOTS) begin
          ring_mem[(ring_head + ring_fill) % RING_SLOTS] = ev.payload_handle;
          ring_fill++;
          if (ring_fill > peak_fill) peak_fill = ring_fill;
          step_pkts.push_back(mk_result(KIND_NEW, next_sq, 16'h0, ev.payload_handle));
          next_sq = next_sq + 16'd1;
        end else begin
          step_pkts.push_back(mk_result(KIND_REFUSED, 16'h0, 16'h0, 16'h0));
        end
      end
      CMD_ACK: begin
        ack_gap = ev.ack_number - base_sq;
        if (ev.ecn_mark) cwnd = cwnd - cwnd / ECN_DIVISOR;
        if (ack_gap == 16'd1 && gap_out >= 16'd1 && ring_fill >= 1) begin
          // in-order ack: grow by one packet, skip duplicate tracking
          cwnd = cwnd + PKT_BYTES;
          if (cwnd > WIN_CAP) cwnd = WIN_CAP;
          drop_acked(1);
        end else begin
          if (ack_gap != 16'd0 && ack_gap < 16'h8000 && ack_gap <= gap_out &&
              ack_gap <= ring_fill)
            drop_acked(ack_gap);
          if (ev.ack_number == last_ack) begin
            dup_cnt = dup_cnt + 2'd1;
          end else begin
            last_ack = ev.ack_number;
            dup_cnt = '0;
          end
          if (dup_cnt == DUP_TRIGGER) begin
            queue_resends();
            cwnd = PKT_BYTES;
            dup_cnt = '0;
          end
        end
      end
      CMD_TIMEOUT: begin
        cwnd = cwnd / 2;
        queue_resends();
      end
      CMD_SYNACK: begin
        step_pkts.push_back(mk_result(KIND_HSK, ev.ack_number + 16'd1,
                                      ev.peer_sequence + 16'd1, 16'h0));
        queue_resends();
      end
      default: ;
    endcase
    if (cwnd < PKT_BYTES) cwnd = PKT_BYTES;
    if (step_pkts.size() == 0) step_pkts.push_back(mk_result(KIND_NONE, 16'h0, 16'h0, 16'h0));
    foreach (step_pkts[i]) begin
      step_pkts[i].congestion_bytes = 16'(cwnd);
      step_pkts[i].last = (i == step_pkts.size() - 1);
      due_results.push_back(step_pkts[i]);
    end
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      CFG_ADV_WIN: win_adv = val[7:0];
      CFG_FIRST_SQ: begin
        base_sq = val;
        next_sq = val;
        ring_head = 0;
        ring_fill = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("packet %0d %s = %h, predicted %h", checked_cnt, fname, got, want));
  endtask

  // Random gap before the next item, with runs of back-to-back items
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Sample handshakes, check emitted packets, update the prediction
  always @(posedge clk) begin : watch_results
    out_item_t want;
    item_acc = rst_n && start && !busy;
    cfg_acc  = rst_n && cfg_valid && cfg_ready;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("packet kind %0d seq %h with nothing outstanding",
                                out_data.kind, out_data.out_sequence));
      end else begin
        want = due_results.pop_front();
        check_field("kind", out_data.kind, want.kind);
        check_field("out_sequence", out_data.out_sequence, want.out_sequence);
        check_field("out_ack_number", out_data.out_ack_number, want.out_ack_number);
        check_field("out_payload", out_data.out_payload, want.out_payload);
        check_field("congestion_bytes", out_data.congestion_bytes, want.congestion_bytes);
        check_field("last", out_data.last, want.last);
        if (want.kind <= KIND_NONE) kind_cnt[want.kind]++;
        checked_cnt++;
      end
    end
    if (item_acc) begin
      predict_sender(in_data);
      events_cnt++;
    end
    if (cfg_acc) begin
      load_register(cfg_index, cfg_data);
      writes_cnt++;
    end
  end

  // Present backlog entries; register writes wait for the block to go idle
  always @(negedge clk) begin : drive_events
    bit             keep_start;
    bit             keep_cfg;
    backlog_entry_t nxt;
    if (rst_n) begin
      keep_start = start && !item_acc;
      keep_cfg   = cfg_valid && !cfg_acc;
      if ((start && item_acc) || (cfg_valid && cfg_acc)) gap_left = draw_gap();
      if (!keep_start && !keep_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_backlog.size() != 0) begin
          if (!event_backlog[0].is_reg) begin
            nxt = event_backlog.pop_front();
            in_data <= nxt.item;
            keep_start = 1'b1;
          end else if (due_results.size() == 0 && !busy) begin
            nxt = event_backlog.pop_front();
            cfg_index <= nxt.reg_idx;
            cfg_data <= nxt.reg_val;
            keep_cfg = 1'b1;
          end
        end
      end
      start <= keep_start;
      cfg_valid <= keep_cfg;
    end
  end

  function automatic in_item_t mk_event(input logic [2:0] cmd, input logic [15:0] handle,
                                        input logic [15:0] ackn, input logic [15:0] peer,
                                        input logic ecn);
    in_item_t it;
    it.command = cmd;
    it.payload_handle = handle;
    it.ack_number = ackn;
    it.peer_sequence = peer;
    it.ecn_mark = ecn;
    return it;
  endfunction

  task automatic push_event(input in_item_t it);
    backlog_entry_t e;
    e.is_reg = 1'b0;
    e.reg_idx = '0;
    e.reg_val = '0;
    e.item = it;
    event_backlog.push_back(e);
  endtask

  // Event with random payload handle and peer sequence
  task automatic push_cmd(input logic [2:0] cmd, input logic [15:0] ackn, input logic ecn);
    push_event(mk_event(cmd, 16'($urandom), ackn, 16'($urandom), ecn));
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    backlog_entry_t e;
    e.is_reg = 1'b1;
    e.reg_idx = idx;
    e.reg_val = val;
    e.item = '0;
    event_backlog.push_back(e);
  endtask

  // Hold until the driver has taken everything queued so far
  task automatic hold_for_backlog();
    while (event_backlog.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic around the current base, plus some noise
  task automatic add_mixed_events(input int n);
    int          added;
    int          pick;
    int          outs;
    logic [15:0] base_view;
    logic [15:0] span;
    bit          mark;
    added = 0;
    while (added < n) begin
      hold_for_backlog();
      base_view = base_sq;
      span = next_sq - base_sq;
      outs = span;
      pick = $urandom_range(0, 99);
      mark = ($urandom_range(0, 7) == 0);
      if (pick < 35) begin
        push_cmd(CMD_DATA, 16'($urandom), mark);
      end else if (pick < 60) begin
        push_cmd(CMD_ACK, base_view + 16'd1, mark);
      end else if (pick < 70) begin
        push_cmd(CMD_ACK, base_view + 16'($urandom_range(1, outs > 0 ? outs : 1)), mark);
      end else if (pick < 78) begin
        push_cmd(CMD_ACK, base_view, mark);
        repeat (3) push_cmd(CMD_ACK, base_view, 1'b0);
        added += 3;
      end else if (pick < 86) begin
        push_cmd(CMD_ACK, 16'($urandom), mark);
      end else if (pick < 92) begin
        push_cmd(CMD_TIMEOUT, 16'($urandom), mark);
      end else if (pick < 96) begin
        push_cmd(CMD_SYNACK, 16'($urandom), mark);
      end else begin
        push_cmd(3'($urandom_range(CMD_OTHER, CMD_LAST_CODE)), 16'($urandom), mark);
      end
      added++;
    end
  endtask

  initial begin : stimulus
    int unsigned phase_adv [4]   = '{2, 1, 40, 255};
    logic [15:0] phase_first [4] = '{16'h0, 16'h0, 16'hFFFF, 16'h0};
    phase_first[0] = 16'($urandom);
    phase_first[3] = 16'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero advertised window, sequences just below the wrap point
    push_reg(CFG_ADV_WIN, 16'd0);
    push_reg(CFG_FIRST_SQ, 16'hFFFE);
    push_event(mk_event(CMD_DATA, 16'hFFFF, 16'h0, 16'h0, 1'b0));
    push_reg(CFG_ADV_WIN, 16'd255);
    // One-packet window: first send goes, second is refused
    push_event(mk_event(CMD_DATA, 16'hFFFF, 16'h0, 16'h0, 1'b0));
    push_event(mk_event(CMD_DATA, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
    push_event(mk_event(CMD_ACK, 16'h0, 16'hFFFF, 16'h1234, 1'b0));
    push_event(mk_event(CMD_DATA, 16'hA5A5, 16'h0, 16'h0, 1'b0));
    push_event(mk_event(CMD_DATA, 16'h5A5A, 16'h0, 16'h0, 1'b0));
    // Timeout with a mark it must ignore, then a handshake reply across the wrap
    push_event(mk_event(CMD_TIMEOUT, 16'h0, 16'h0, 16'h0, 1'b1));
    push_event(mk_event(CMD_SYNACK, 16'h0, 16'hFFFF, 16'hFFFF, 1'b0));
    // Acks past the sent data, one at half the sequence space away
    push_event(mk_event(CMD_ACK, 16'h0, 16'h0063, 16'h0, 1'b0));
    push_event(mk_event(CMD_ACK, 16'h0, 16'h7FFF, 16'h0, 1'b0));
    // Repeated ack at the base: the third duplicate resends all
    push_event(mk_event(CMD_ACK, 16'h0, 16'hFFFF, 16'h0, 1'b1));
    repeat (3) push_event(mk_event(CMD_ACK, 16'h0, 16'hFFFF, 16'h0, 1'b0));
    // Cumulative ack clears the ring, then resends with nothing to send
    push_event(mk_event(CMD_ACK, 16'h0, 16'h0001, 16'h0, 1'b0));
    push_event(mk_event(CMD_TIMEOUT, 16'h0, 16'h0, 16'h0, 1'b0));
    push_event(mk_event(CMD_SYNACK, 16'h0, 16'h0, 16'h0, 1'b0));
    for (int c = CMD_OTHER; c <= CMD_LAST_CODE; c++)
      push_event(mk_event(3'(c), 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    push_event(mk_event(CMD_ACK, 16'h0, 16'($urandom), 16'h0, 1'b1));

    // Grow the window with send/ack pairs, then flood until the ring is full
    push_reg(CFG_ADV_WIN, 16'd255);
    push_reg(CFG_FIRST_SQ, 16'($urandom));
    repeat (35) begin
      push_cmd(CMD_DATA, 16'($urandom), 1'($urandom));
      hold_for_backlog();
      push_cmd(CMD_ACK, base_sq + 16'd1, 1'b0);
    end
    repeat (40) push_cmd(CMD_DATA, 16'($urandom), 1'($urandom));
    push_cmd(CMD_TIMEOUT, 16'($urandom), 1'($urandom));
    push_cmd(CMD_SYNACK, 16'($urandom), 1'($urandom));
    hold_for_backlog();
    repeat (4) push_cmd(CMD_ACK, base_sq, 1'b0);

    // Mixed traffic under several window and sequence settings
    foreach (phase_adv[p]) begin
      push_reg(CFG_ADV_WIN, 16'(phase_adv[p]));
      push_reg(CFG_FIRST_SQ, phase_first[p]);
      add_mixed_events(30);
    end

    // Drain, then allow the block's tail latency
    while (event_backlog.size() != 0 || start || cfg_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d events and %0d register writes; %0d packets checked",
             events_cnt, writes_cnt, checked_cnt);
    $display("sent %0d, resent %0d, handshake %0d, refused %0d, quiet %0d; ring peak %0d of %0d",
             kind_cnt[KIND_NEW], kind_cnt[KIND_RETX], kind_cnt[KIND_HSK],
             kind_cnt[KIND_REFUSED], kind_cnt[KIND_NONE], peak_fill, RING_SLOTS);
    if (mismatch_cnt == 0) begin
      $display("go_back_n_sender_window_unit_tb: done, clean");
    end else begin
      $display("go_back_n_sender_window_unit_tb: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #1_000_000;
    $display("watchdog expired: %0d packets outstanding, %0d events queued",
             due_results.size(), event_backlog.size());
    $display("go_back_n_sender_window_unit_tb: done, errors");
    $finish;
  end

endmodule
